// File: rtl/sfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame classifier package
// Shared widths, register indexes, frame constants, kind codes and types.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int CAPTURE_BYTES = 14;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
	localparam logic [CNT_W-1:0] MIN_FRAME_LEN = 4'd8;
	localparam int MAP_W = 64;
	localparam int MAP_BITS = 256;
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MAP_0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MAP_1 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MAP_2 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MAP_3 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_MAP_0  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_MAP_1  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_MAP_2  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_MAP_3  = 4'd7;

	// Frame framing and command bytes.
	localparam logic [7:0] HDR_BYTE   = 8'hAA;
	localparam logic [7:0] TAIL_BYTE  = 8'h55;
	localparam logic [7:0] CMD_E      = 8'h45;
	localparam logic [7:0] CMD_C      = 8'h43;
	localparam logic [7:0] CMD_D      = 8'h44;
	localparam logic [7:0] CMD_K      = 8'h4B;
	localparam logic [7:0] CMD_M      = 8'h4D;
	localparam logic [7:0] CMD_P      = 8'h50;
	localparam logic [7:0] CMD_O      = 8'h4F;
	localparam logic [7:0] CMD_T      = 8'h54;
	localparam logic [7:0] CMD_Q      = 8'h51;
	localparam logic [7:0] CMD_A      = 8'h41;
	localparam logic [7:0] CMD_B      = 8'h42;
	localparam logic [7:0] CMD_F      = 8'h46;
	localparam logic [7:0] VAL_ZERO   = 8'h00;
	localparam logic [7:0] VAL_ONE    = 8'h01;
	localparam logic [7:0] VAL_CC     = 8'h80;
	localparam logic [7:0] VAL_CAR_UP = 8'h80;
	localparam logic [7:0] VAL_CAR_DN = 8'h81;

	localparam logic [3:0] CARD_PAYLOAD_BYTES = 4'd3;
	localparam logic [3:0] DISP_PAYLOAD_BYTES = 4'd8;

	// Frame kind codes.
	localparam logic [4:0] K_NONE             = 5'd0;
	localparam logic [4:0] K_SUCCESS          = 5'd1;
	localparam logic [4:0] K_FAILED           = 5'd2;
	localparam logic [4:0] K_CC_EXIST         = 5'd3;
	localparam logic [4:0] K_IN_EXIST         = 5'd4;
	localparam logic [4:0] K_OUT_EXIST        = 5'd5;
	localparam logic [4:0] K_CARD             = 5'd6;
	localparam logic [4:0] K_DISPENSER        = 5'd7;
	localparam logic [4:0] K_AUDIO_END        = 5'd8;
	localparam logic [4:0] K_IN_BALLOT_LEAVE  = 5'd9;
	localparam logic [4:0] K_IN_BALLOT_ENTER  = 5'd10;
	localparam logic [4:0] K_OUT_BALLOT_LEAVE = 5'd11;
	localparam logic [4:0] K_OUT_BALLOT_ENTER = 5'd12;
	localparam logic [4:0] K_BTN_UP_NOCAR     = 5'd13;
	localparam logic [4:0] K_BTN_DOWN_NOCAR   = 5'd14;
	localparam logic [4:0] K_BTN_UP_CAR       = 5'd15;
	localparam logic [4:0] K_BTN_DOWN_CAR     = 5'd16;
	localparam logic [4:0] K_IN_GATE_LEAVE    = 5'd17;
	localparam logic [4:0] K_IN_GATE_ENTER    = 5'd18;
	localparam logic [4:0] K_OUT_GATE_LEAVE   = 5'd19;
	localparam logic [4:0] K_OUT_GATE_ENTER   = 5'd20;
	localparam logic [4:0] K_Q_SENSE_CAR      = 5'd21;
	localparam logic [4:0] K_Q_SENSE_NOCAR    = 5'd22;
	localparam logic [4:0] K_Q_BTN_OPEN       = 5'd23;
	localparam logic [4:0] K_Q_BTN_CLOSE      = 5'd24;
	localparam logic [4:0] K_Q_GATE_CAR       = 5'd25;
	localparam logic [4:0] K_Q_GATE_NOCAR     = 5'd26;
	localparam logic [4:0] K_Q_CONTROLLER     = 5'd27;

	// Snapshot of a closed frame, handed from capture to classification.
	typedef struct packed {
		logic [CAPTURE_BYTES-1:0][7:0] head;
		logic                          frame_ok;
		logic [7:0]                    prev_byte;
	} frame_snap_t;

	// A zero selects the first kind, a one the second, anything else none.
	function automatic logic [4:0] pick2(input logic [7:0] b, input logic [4:0] on0,
			input logic [4:0] on1);
		logic [4:0] k;
		if (b == VAL_ZERO) begin
			k = on0;
		end else if (b == VAL_ONE) begin
			k = on1;
		end else begin
			k = K_NONE;
		end
		return k;
	endfunction

endpackage

// File: rtl/sfc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate address map registers
// Holds the entry and exit gate bitmaps written through the config port.
// ----------------------------------------------------------------------------
module sfc_cfg_regs
	import sfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MAP_W-1:0]     cfg_data,
	output logic [MAP_BITS-1:0]  entry_map,
	output logic [MAP_BITS-1:0]  exit_map
);

	logic [MAP_W-1:0] entry0_q, entry1_q, entry2_q, entry3_q;
	logic [MAP_W-1:0] exit0_q, exit1_q, exit2_q, exit3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry0_q <= '0;
			entry1_q <= '0;
			entry2_q <= '0;
			entry3_q <= '0;
			exit0_q  <= '0;
			exit1_q  <= '0;
			exit2_q  <= '0;
			exit3_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_MAP_0: entry0_q <= cfg_data;
				REG_ENTRY_MAP_1: entry1_q <= cfg_data;
				REG_ENTRY_MAP_2: entry2_q <= cfg_data;
				REG_ENTRY_MAP_3: entry3_q <= cfg_data;
				REG_EXIT_MAP_0:  exit0_q  <= cfg_data;
				REG_EXIT_MAP_1:  exit1_q  <= cfg_data;
				REG_EXIT_MAP_2:  exit2_q  <= cfg_data;
				REG_EXIT_MAP_3:  exit3_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign entry_map = {entry3_q, entry2_q, entry1_q, entry0_q};
	assign exit_map  = {exit3_q, exit2_q, exit1_q, exit0_q};

endmodule

// File: rtl/sfc_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte capture
// Counts bytes, keeps the frame head and the previous byte, and registers a
// snapshot of the frame when its final byte arrives.
// ----------------------------------------------------------------------------
module sfc_capture
	import sfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  frame_byte,
	input  logic        end_of_frame,
	input  logic        snap_take,
	output logic        snap_valid_s1,
	output frame_snap_t snap_s1
);

	logic [CNT_W-1:0]              count_q;
	logic [CAPTURE_BYTES-1:0][7:0] head_q;
	logic [7:0]                    prev_q;

	logic [CNT_W-1:0]              count_next;
	logic [CAPTURE_BYTES-1:0][7:0] head_next;
	frame_snap_t                   snap_next;

	always_comb begin
		head_next = head_q;
		for (int i = 0; i < CAPTURE_BYTES; i++) begin
			if (count_q == CNT_W'(i)) begin
				head_next[i] = frame_byte;
			end
		end
		count_next = (count_q == CNT_MAX) ? CNT_MAX : count_q + 1'b1;

		// Entries past the byte count stay zero, so short frames read zero there.
		snap_next.head      = head_next;
		snap_next.prev_byte = prev_q;
		snap_next.frame_ok  = (count_next >= MIN_FRAME_LEN) && (head_next[0] == HDR_BYTE) &&
			(frame_byte == TAIL_BYTE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			prev_q  <= '0;
		end else if (accept) begin
			if (end_of_frame) begin
				count_q <= '0;
				head_q  <= '0;
				prev_q  <= '0;
			end else begin
				count_q <= count_next;
				head_q  <= head_next;
				prev_q  <= frame_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (accept && end_of_frame) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_take) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_frame) begin
			snap_s1 <= snap_next;
		end
	end

endmodule

// File: rtl/sfc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame classification
// Decodes the frame kind from a snapshot and registers the result fields.
// ----------------------------------------------------------------------------
module sfc_classify
	import sfc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                snap_valid_s1,
	input  frame_snap_t         snap_s1,
	input  logic [MAP_BITS-1:0] entry_map,
	input  logic [MAP_BITS-1:0] exit_map,
	input  logic                out_stall,
	output logic                snap_take,
	output logic                out_valid,
	output logic [4:0]          frame_kind,
	output logic [15:0]         length_field,
	output logic [7:0]          node_address,
	output logic [7:0]          checksum_byte,
	output logic [63:0]         payload,
	output logic [3:0]          payload_bytes
);

	logic       out_free;
	logic [7:0] b3, b4, b5, b6;
	logic       in_hit, out_hit;
	logic [4:0] kind;
	logic [4:0] kind_d;
	logic [15:0] len_d;
	logic [7:0]  addr_d, csum_d;
	logic [63:0] pay_d;
	logic [3:0]  nbytes_d;

	assign out_free  = !out_valid || !out_stall;
	assign snap_take = snap_valid_s1 && out_free;

	assign b3 = snap_s1.head[3];
	assign b4 = snap_s1.head[4];
	assign b5 = snap_s1.head[5];
	assign b6 = snap_s1.head[6];
	assign in_hit  = entry_map[b5];
	assign out_hit = exit_map[b5];

	always_comb begin
		kind = K_NONE;
		if (b3 == CMD_E) begin
			if (b4 == CMD_C) begin
				kind = pick2(b6, K_SUCCESS, K_FAILED);
			end else if (b4 == CMD_D) begin
				if (b5 == VAL_CC) begin
					kind = K_CC_EXIST;
				end else if (in_hit) begin
					kind = K_IN_EXIST;
				end else if (out_hit) begin
					kind = K_OUT_EXIST;
				end
			end
		end else if (b3 == CMD_K && (b4 == VAL_ZERO || b4 == VAL_ONE)) begin
			kind = K_CARD;
		end else if (b3 == CMD_M && b4 == CMD_C) begin
			kind = K_DISPENSER;
		end else if (b3 == CMD_P && b4 == CMD_O) begin
			kind = K_AUDIO_END;
		end else if (b3 == CMD_T) begin
			if (b4 == CMD_B) begin
				if (in_hit) begin
					kind = pick2(b6, K_IN_BALLOT_LEAVE, K_IN_BALLOT_ENTER);
				end else if (out_hit) begin
					kind = pick2(b6, K_OUT_BALLOT_LEAVE, K_OUT_BALLOT_ENTER);
				end
			end else if (b4 == CMD_C) begin
				if (b6 == VAL_CAR_UP) begin
					kind = K_BTN_UP_CAR;
				end else if (b6 == VAL_CAR_DN) begin
					kind = K_BTN_DOWN_CAR;
				end else begin
					kind = pick2(b6, K_BTN_UP_NOCAR, K_BTN_DOWN_NOCAR);
				end
			end else if (b4 == CMD_D) begin
				kind = pick2(b6, K_BTN_UP_CAR, K_BTN_DOWN_CAR);
			end else if (b4 == CMD_F) begin
				if (in_hit) begin
					kind = pick2(b6, K_IN_GATE_LEAVE, K_IN_GATE_ENTER);
				end else if (out_hit) begin
					kind = pick2(b6, K_OUT_GATE_LEAVE, K_OUT_GATE_ENTER);
				end
			end
		end else if (b3 == CMD_Q) begin
			if (b4 == CMD_B) begin
				kind = pick2(b6, K_Q_SENSE_CAR, K_Q_SENSE_NOCAR);
			end else if (b4 == CMD_C) begin
				kind = pick2(b6, K_Q_BTN_OPEN, K_Q_BTN_CLOSE);
			end else if (b4 == CMD_F) begin
				kind = pick2(b6, K_Q_GATE_CAR, K_Q_GATE_NOCAR);
			end else if (b4 == CMD_A) begin
				kind = K_Q_CONTROLLER;
			end
		end
	end

	always_comb begin
		kind_d   = '0;
		len_d    = '0;
		addr_d   = '0;
		csum_d   = '0;
		pay_d    = '0;
		nbytes_d = '0;
		// A rejected frame reports every field as zero.
		if (snap_s1.frame_ok) begin
			kind_d = kind;
			len_d  = {snap_s1.head[2], snap_s1.head[1]};
			addr_d = b5;
			csum_d = snap_s1.prev_byte;
			if (kind == K_CARD) begin
				nbytes_d = CARD_PAYLOAD_BYTES;
				pay_d    = {40'd0, snap_s1.head[8], snap_s1.head[7], snap_s1.head[6]};
			end else if (kind == K_DISPENSER) begin
				nbytes_d = DISP_PAYLOAD_BYTES;
				pay_d    = {snap_s1.head[13], snap_s1.head[12], snap_s1.head[11],
					snap_s1.head[10], snap_s1.head[9], snap_s1.head[8],
					snap_s1.head[7], snap_s1.head[6]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= snap_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_take) begin
			frame_kind    <= kind_d;
			length_field  <= len_d;
			node_address  <= addr_d;
			checksum_byte <= csum_d;
			payload       <= pay_d;
			payload_bytes <= nbytes_d;
		end
	end

endmodule

// File: rtl/serial_frame_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame classifier
// Takes uplink frame bytes, one per cycle unless stalled, and gives one
// classified result per frame: kind, length field, address, checksum byte and
// payload. Two register stages: the snapshot register and the result register.
// Throughput: one byte per cycle unless in_stall is high; the snapshot and
// result registers let a new frame proceed while a result waits to be taken.
// Reset clears the gate maps, the byte count and the captured frame bytes.
// ----------------------------------------------------------------------------
module serial_frame_classifier_unit
	import sfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           frame_byte,
	input  logic                 end_of_frame,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [4:0]           frame_kind,
	output logic [15:0]          length_field,
	output logic [7:0]           node_address,
	output logic [7:0]           checksum_byte,
	output logic [63:0]          payload,
	output logic [3:0]           payload_bytes,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MAP_W-1:0]     cfg_data
);

	logic                accept;
	logic                snap_valid_s1;
	logic                snap_take;
	frame_snap_t         snap_s1;
	logic [MAP_BITS-1:0] entry_map;
	logic [MAP_BITS-1:0] exit_map;

	// Stall only when a snapshot is parked and cannot move into the result register.
	assign in_stall = snap_valid_s1 && !snap_take;
	assign accept   = in_valid && !in_stall;

	sfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.entry_map (entry_map),
		.exit_map  (exit_map)
	);

	sfc_capture u_capture (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.frame_byte    (frame_byte),
		.end_of_frame  (end_of_frame),
		.snap_take     (snap_take),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1)
	);

	sfc_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.entry_map     (entry_map),
		.exit_map      (exit_map),
		.out_stall     (out_stall),
		.snap_take     (snap_take),
		.out_valid     (out_valid),
		.frame_kind    (frame_kind),
		.length_field  (length_field),
		.node_address  (node_address),
		.checksum_byte (checksum_byte),
		.payload       (payload),
		.payload_bytes (payload_bytes)
	);

endmodule
